// ===== sv/rrs_pkg.sv =====
// shared widths and helpers for the rectangle region statistics block
`default_nettype none
package rrs_pkg;
  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam int unsigned PixW   = 8;
  localparam int unsigned CoordW = 8;
  localparam int unsigned RegW   = 9;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned SumW   = 24;
  localparam int unsigned SqW    = 32;
  localparam int unsigned NumCh  = 3;
  localparam int unsigned EntryW = NumCh * (SumW + SqW);
  localparam int unsigned AreaW  = 2 * CoordW + 1;
  localparam int unsigned NumW   = 2 * SumW;
  localparam int unsigned ScoreW = 34;
  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;
  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  function automatic logic [SizeW-1:0] eff_size(input logic [RegW-1:0] r, input int unsigned mx);
    logic [SizeW-1:0] v;
    v = SizeW'(r);
    if (v == '0) return SizeW'(1);
    if (v > SizeW'(mx)) return SizeW'(mx);
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== sv/rrs_ram.sv =====
// generic ram with one write port and two registered read ports
`default_nettype none
module rrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AddrW-1:0]      waddr_i,
  input  wire logic [Width-1:0]      wdata_i,
  input  wire logic [AddrW-1:0]      raddr0_i,
  input  wire logic [AddrW-1:0]      raddr1_i,
  output logic      [Width-1:0]      rdata0_o,
  output logic      [Width-1:0]      rdata1_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end
endmodule
`default_nettype wire

// ===== sv/rrs_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module rrs_div #(
  parameter int unsigned NumWidth = 48,
  parameter int unsigned DivWidth = 17
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [NumWidth-1:0] num_i,
  input  wire logic [DivWidth-1:0] div_i,
  output logic      [NumWidth-1:0] quo_o,
  output logic                     done_o
);
  localparam int unsigned CntW = $clog2(NumWidth);
  logic [NumWidth-1:0] quo_q, quo_d;
  logic [DivWidth-1:0] rem_q, rem_d, div_q;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q, done_q;
  logic [DivWidth:0]   shifted;
  logic                take;

  always_comb begin
    shifted = {rem_q, quo_q[NumWidth-1]};
    take    = shifted >= {1'b0, div_q};
    rem_d   = take ? DivWidth'(shifted - {1'b0, div_q}) : DivWidth'(shifted);
    quo_d   = {quo_q[NumWidth-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NumWidth - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      div_q <= div_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

// ===== sv/rect_region_statistics.sv =====
// rectangle region statistics over summed-area tables of rgb sums and squared sums
// load: per pixel a table read, then add and write back; no result
// query: two table reads, region sums, squares, then dividers; a rejected query goes straight to the result
// a finished result waits in the output register; a query stalls only while it is full and the output is stalled
// one request in work at a time
// reset clears load position, image-loaded flag and registers (256 x 256); table ram is not cleared
`default_nettype none
module rect_region_statistics #(
  parameter int unsigned MAX_WIDTH  = rrs_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = rrs_pkg::DefMaxHeight
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_addr_i,
  input  wire logic [rrs_pkg::RegW-1:0]     cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         mode_i,
  input  wire logic [rrs_pkg::PixW-1:0]     red_value_i,
  input  wire logic [rrs_pkg::PixW-1:0]     green_value_i,
  input  wire logic [rrs_pkg::PixW-1:0]     blue_value_i,
  input  wire logic [rrs_pkg::CoordW-1:0]   left_x_i,
  input  wire logic [rrs_pkg::CoordW-1:0]   top_y_i,
  input  wire logic [rrs_pkg::CoordW-1:0]   right_x_i,
  input  wire logic [rrs_pkg::CoordW-1:0]   bottom_y_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [rrs_pkg::ScoreW-1:0]        variance_score_o,
  output logic [rrs_pkg::PixW-1:0]          avg_red_o,
  output logic [rrs_pkg::PixW-1:0]          avg_green_o,
  output logic [rrs_pkg::PixW-1:0]          avg_blue_o,
  output logic                              rect_error_o
);
  localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 2 ** AW;
  localparam int unsigned SumW  = rrs_pkg::SumW;
  localparam int unsigned SqW   = rrs_pkg::SqW;
  localparam int unsigned SqOff = rrs_pkg::NumCh * SumW;
  localparam int unsigned SizeW = rrs_pkg::SizeW;
  localparam int unsigned NumW  = rrs_pkg::NumW;
  localparam int unsigned ScoreW = rrs_pkg::ScoreW;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_WR, S_Q_RD0, S_Q_RD1, S_Q_SUM, S_Q_MUL, S_Q_START, S_Q_DIV, S_Q_FIN
  } state_e;

  state_e state_q;
  logic [rrs_pkg::RegW-1:0] width_q, height_q;
  logic [SizeW-1:0] w_eff, h_eff;
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic [SqOff-1:0] last_sum_q;
  logic [rrs_pkg::NumCh*SqW-1:0] last_sq_q;
  logic loaded_q;
  logic [3*rrs_pkg::PixW-1:0] pix_q;
  logic [rrs_pkg::CoordW-1:0] l_q, t_q, r_q, b_q;
  logic [rrs_pkg::AreaW-1:0] area_q;
  logic err_q;
  logic [rrs_pkg::EntryW-1:0] ent_a_q, ent_b_q;
  logic [rrs_pkg::NumCh*SumW-1:0] s_q;
  logic [rrs_pkg::NumCh*SqW-1:0] q_q;
  logic [rrs_pkg::NumCh*NumW-1:0] ss_q;
  logic out_valid_q;
  logic [ScoreW-1:0] score_q;
  logic [3*rrs_pkg::PixW-1:0] avg_q;

  logic accept, q_err;
  logic we;
  logic [AW-1:0] waddr, raddr0, raddr1;
  logic [rrs_pkg::EntryW-1:0] wdata, rdata0, rdata1;
  logic [rrs_pkg::NumCh*SumW-1:0] s_new, s_tot;
  logic [rrs_pkg::NumCh*SqW-1:0] q_new, q_tot;
  logic [rrs_pkg::NumCh*NumW-1:0] quo_s, quo_ss;
  logic [2*rrs_pkg::NumCh-1:0] div_done;
  logic div_start;
  logic [ScoreW-1:0] score_d;
  logic [XW-1:0] xm1, lm1;
  logic [YW-1:0] ym1, tm1;
  logic l_pos, t_pos;

  assign w_eff = rrs_pkg::eff_size(width_q, MAX_WIDTH);
  assign h_eff = rrs_pkg::eff_size(height_q, MAX_HEIGHT);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign q_err = !loaded_q || (left_x_i > right_x_i) || (top_y_i > bottom_y_i)
                 || (SizeW'(right_x_i) >= w_eff) || (SizeW'(bottom_y_i) >= h_eff);

  assign xm1 = col_q - XW'(1);
  assign ym1 = row_q - YW'(1);
  assign lm1 = XW'(l_q - rrs_pkg::CoordW'(1));
  assign tm1 = YW'(t_q - rrs_pkg::CoordW'(1));
  assign l_pos = (l_q != '0);
  assign t_pos = (t_q != '0);

  always_comb begin
    raddr0 = {xm1, row_q};
    raddr1 = {xm1, ym1};
    unique case (state_q)
      S_Q_RD0: begin
        raddr0 = {XW'(r_q), YW'(b_q)};
        raddr1 = {XW'(r_q), tm1};
      end
      S_Q_RD1: begin
        raddr0 = {lm1, YW'(b_q)};
        raddr1 = {lm1, tm1};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < rrs_pkg::NumCh; c++) begin
      logic [SumW-1:0] s;
      logic [SqW-1:0]  q;
      logic [rrs_pkg::PixW-1:0] p;
      p = pix_q[c*rrs_pkg::PixW +: rrs_pkg::PixW];
      s = SumW'(p) + last_sum_q[c*SumW +: SumW];
      q = SqW'(p) * SqW'(p) + last_sq_q[c*SqW +: SqW];
      if (col_q != '0) begin
        s = s + rdata0[c*SumW +: SumW];
        q = q + rdata0[SqOff + c*SqW +: SqW];
        if (row_q != '0) begin
          s = s - rdata1[c*SumW +: SumW];
          q = q - rdata1[SqOff + c*SqW +: SqW];
        end
      end
      s_new[c*SumW +: SumW] = s;
      q_new[c*SqW +: SqW]   = q;
      s = ent_a_q[c*SumW +: SumW];
      q = ent_a_q[SqOff + c*SqW +: SqW];
      if (t_pos) begin
        s = s - ent_b_q[c*SumW +: SumW];
        q = q - ent_b_q[SqOff + c*SqW +: SqW];
      end
      if (l_pos) begin
        s = s - rdata0[c*SumW +: SumW];
        q = q - rdata0[SqOff + c*SqW +: SqW];
      end
      if (l_pos && t_pos) begin
        s = s + rdata1[c*SumW +: SumW];
        q = q + rdata1[SqOff + c*SqW +: SqW];
      end
      s_tot[c*SumW +: SumW] = s;
      q_tot[c*SqW +: SqW]   = q;
    end
  end

  assign we    = (state_q == S_LD_WR);
  assign waddr = {col_q, row_q};
  assign wdata = {q_new, s_new};

  rrs_ram #(.Width(rrs_pkg::EntryW), .Depth(Depth)) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  assign div_start = (state_q == S_Q_START);

  for (genvar c = 0; c < rrs_pkg::NumCh; c++) begin : g_ch
    rrs_div #(.NumWidth(NumW), .DivWidth(rrs_pkg::AreaW)) u_div_s (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (NumW'(s_q[c*SumW +: SumW])),
      .div_i   (area_q),
      .quo_o   (quo_s[c*NumW +: NumW]),
      .done_o  (div_done[2*c])
    );
    rrs_div #(.NumWidth(NumW), .DivWidth(rrs_pkg::AreaW)) u_div_ss (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (ss_q[c*NumW +: NumW]),
      .div_i   (area_q),
      .quo_o   (quo_ss[c*NumW +: NumW]),
      .done_o  (div_done[2*c+1])
    );
  end

  always_comb begin
    score_d = '0;
    for (int c = 0; c < rrs_pkg::NumCh; c++) begin
      score_d = score_d + ScoreW'(q_q[c*SqW +: SqW]) - ScoreW'(quo_ss[c*NumW +: NumW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= rrs_pkg::RegW'(256);
      height_q    <= rrs_pkg::RegW'(256);
      col_q       <= '0;
      row_q       <= '0;
      last_sum_q  <= '0;
      last_sq_q   <= '0;
      loaded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      if (state_q == S_Q_FIN && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          rrs_pkg::RegImageWidth:  width_q  <= cfg_wdata_i;
          rrs_pkg::RegImageHeight: height_q <= cfg_wdata_i;
          default: begin
          end
        endcase
        col_q      <= '0;
        row_q      <= '0;
        last_sum_q <= '0;
        last_sq_q  <= '0;
        loaded_q   <= 1'b0;
      end else if (state_q == S_LD_WR) begin
        if ((SizeW'(row_q) + SizeW'(1)) < h_eff) begin
          row_q      <= row_q + YW'(1);
          last_sum_q <= s_new;
          last_sq_q  <= q_new;
          loaded_q   <= 1'b0;
        end else begin
          row_q      <= '0;
          last_sum_q <= '0;
          last_sq_q  <= '0;
          if ((SizeW'(col_q) + SizeW'(1)) < w_eff) begin
            col_q    <= col_q + XW'(1);
            loaded_q <= 1'b0;
          end else begin
            col_q    <= '0;
            loaded_q <= 1'b1;
          end
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (mode_i == rrs_pkg::ModeLoad) begin
              state_q <= S_LD_RD;
            end else begin
              err_q   <= q_err;
              state_q <= q_err ? S_Q_FIN : S_Q_RD0;
            end
          end
        end
        S_LD_RD:   state_q <= S_LD_WR;
        S_LD_WR:   state_q <= S_IDLE;
        S_Q_RD0:   state_q <= S_Q_RD1;
        S_Q_RD1:   state_q <= S_Q_SUM;
        S_Q_SUM:   state_q <= S_Q_MUL;
        S_Q_MUL:   state_q <= S_Q_START;
        S_Q_START: state_q <= S_Q_DIV;
        S_Q_DIV: begin
          if (&div_done) begin
            state_q <= S_Q_FIN;
          end
        end
        S_Q_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= {blue_value_i, green_value_i, red_value_i};
      l_q    <= left_x_i;
      t_q    <= top_y_i;
      r_q    <= right_x_i;
      b_q    <= bottom_y_i;
      area_q <= rrs_pkg::AreaW'((rrs_pkg::AreaW'(right_x_i - left_x_i) + rrs_pkg::AreaW'(1))
                * (rrs_pkg::AreaW'(bottom_y_i - top_y_i) + rrs_pkg::AreaW'(1)));
    end
    if (state_q == S_Q_RD1) begin
      ent_a_q <= rdata0;
      ent_b_q <= rdata1;
    end
    if (state_q == S_Q_SUM) begin
      s_q <= s_tot;
      q_q <= q_tot;
    end
    if (state_q == S_Q_MUL) begin
      for (int c = 0; c < rrs_pkg::NumCh; c++) begin
        ss_q[c*NumW +: NumW] <= s_q[c*SumW +: SumW] * s_q[c*SumW +: SumW];
      end
    end
    if (state_q == S_Q_FIN && (!out_valid_q || !out_stall_i)) begin
      if (err_q) begin
        score_q <= '0;
        avg_q   <= '0;
      end else begin
        score_q <= score_d;
        for (int c = 0; c < rrs_pkg::NumCh; c++) begin
          avg_q[c*rrs_pkg::PixW +: rrs_pkg::PixW] <= rrs_pkg::PixW'(quo_s[c*NumW +: NumW]);
        end
      end
      rect_error_o <= err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign variance_score_o = score_q;
  assign avg_red_o        = avg_q[0 +: rrs_pkg::PixW];
  assign avg_green_o      = avg_q[rrs_pkg::PixW +: rrs_pkg::PixW];
  assign avg_blue_o       = avg_q[2*rrs_pkg::PixW +: rrs_pkg::PixW];
endmodule
`default_nettype wire
